FILE: rtl/rbp_pkg.sv
// ============================================================================
// rbp_pkg
// Shared types and constants for the random bit pool with geometric sampler.
// ============================================================================
`default_nettype none

package rbp_pkg;

    // field widths
    localparam int BIT_COUNT_W   = 6;
    localparam int BOUND_W       = 32;
    localparam int WORD_W        = 64;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int USED_W        = 64;
    localparam int COUNT_W       = 33;

    // stream widths
    localparam int IN_TDATA_W    = 104;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 104;

    // largest bits request
    localparam int MAX_REQUEST_BITS = 32;

    // command codes on the input tuser
    localparam logic [1:0] CMD_BITS = 2'd0;
    localparam logic [1:0] CMD_GEOM = 2'd1;
    localparam logic [1:0] CMD_WORD = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVAL   = 3'd1;
    localparam logic [2:0] ST_SRC     = 3'd2;
    localparam logic [2:0] ST_BOUND   = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;

    // sticky error codes (low bits of the matching status)
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SRC   = 2'd2;
    localparam logic [1:0] ERR_BOUND = 2'd3;

    // classified operation
    typedef enum logic [1:0] {
        OP_BITS = 2'd0,
        OP_GEOM = 2'd1,
        OP_WORD = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // kind of the pending request
    typedef enum logic [2:0] {
        KIND_NONE = 3'b001,
        KIND_BITS = 3'b010,
        KIND_GEOM = 3'b100
    } kind_t;

    // one queued request
    typedef struct packed {
        op_t                    op;
        logic                   too_many;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [BOUND_W-1:0]     bound;
        logic [WORD_W-1:0]      source_word;
        logic                   source_fail;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/random_bit_pool_with_geometric_sampler.sv
// ============================================================================
// random_bit_pool_with_geometric_sampler
// Random bit pool serving bits requests and geometric samples, refilled one
// source word at a time.
// ============================================================================
//
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  s_tdata: bit_count, bound, source_word,
//                                    source_fail; s_tuser: command
// m_       out  m_tvalid / m_tready  m_tdata: value, status, done_res,
//                                    need_word, used_bits
//
// one request per cycle sustained while results are taken; each request does one
// pool step (masked shift or trailing-zero count) in the execution unit
// an accepted request waits in the input queue, and its result is registered onto m_
// reset clears the pool, counters, sticky error and pending request at once
// while a result waits on m_tready the two-entry input queue takes up to two
// more requests, then s_tready drops until the result is taken
// ============================================================================
`default_nettype none

module random_bit_pool_with_geometric_sampler
    import rbp_pkg::*;
#(
    parameter int POOL_WIDTH = 64
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // bit_count[5:0], bound[37:6], source_word[101:38], source_fail[102]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // value[31:0], status[34:32], done_res[35], need_word[36], used_bits[100:37]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // request decode and queue
    rbp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // pool and request execution
    rbp_back #(
        .POOL_WIDTH (POOL_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/rbp_front.sv
// ============================================================================
// rbp_front
// Accepts requests, decodes the command and checks the bit count, and holds
// them in a two-entry queue in front of the execution unit.
// ============================================================================
`default_nettype none

module rbp_front
    import rbp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // bit_count[5:0], bound[37:6], source_word[101:38], source_fail[102]
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  wire logic [IN_TUSER_W-1:0] s_tuser,
    output logic                       q_valid,
    output item_t                      q_item,
    input  wire logic                  q_pop
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       in_item;
    logic        push;

    // decode the command and flag oversized bit requests
    always_comb begin
        in_item.bit_count   = s_tdata[5:0];
        in_item.bound       = s_tdata[37:6];
        in_item.source_word = s_tdata[101:38];
        in_item.source_fail = s_tdata[102];
        in_item.too_many    = (32'(s_tdata[5:0]) > MAX_REQUEST_BITS);
        unique case (s_tuser)
            CMD_BITS: begin
                in_item.op = OP_BITS;
            end
            CMD_GEOM: begin
                in_item.op = OP_GEOM;
            end
            CMD_WORD: begin
                in_item.op = OP_WORD;
            end
            CMD_NOP: begin
                in_item.op = OP_NOP;
            end
        endcase
    end

    // queue handshakes
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rbp_back.sv
// ============================================================================
// rbp_back
// Execution unit: holds the bit pool and the pending request, advances the
// request by one pool step per item and registers the result.
// ============================================================================
`default_nettype none

module rbp_back
    import rbp_pkg::*;
#(
    parameter int POOL_WIDTH = 64
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire item_t                  q_item,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // value[31:0], status[34:32], done_res[35], need_word[36], used_bits[100:37]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int LW = $clog2(POOL_WIDTH + 1);

    logic [POOL_WIDTH-1:0]  pool_reg,   pool_next;
    logic [LW-1:0]          left_reg,   left_next;
    logic [USED_W-1:0]      used_reg,   used_next;
    logic [1:0]             err_reg,    err_next;
    kind_t                  kind_reg,   kind_next;
    logic [VALUE_W-1:0]     value_reg,  value_next;
    logic [5:0]             offset_reg, offset_next;
    logic [5:0]             target_reg, target_next;
    logic [COUNT_W-1:0]     count_reg,  count_next;
    logic [BOUND_W-1:0]     bound_reg,  bound_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    logic                   fire;
    logic                   run;
    logic [2:0]             st;
    logic [VALUE_W-1:0]     val;
    logic                   done;
    logic                   need;
    logic [LW-1:0]          take;
    logic [LW-1:0]          zeros;
    logic [5:0]             rem;
    logic [32:0]            take_mask;
    logic [VALUE_W-1:0]     drawn;

    // saturating add to the consumed-bit count
    function automatic logic [USED_W-1:0] sat_add(input logic [USED_W-1:0] u,
                                                  input logic [LW-1:0] inc);
        logic [USED_W:0] sum;
        sum = {1'b0, u} + (USED_W + 1)'(inc);
        return sum[USED_W] ? {USED_W{1'b1}} : sum[USED_W-1:0];
    endfunction

    assign fire  = q_valid && (!m_tvalid_reg || m_tready);
    assign q_pop = fire;

    // one item: start or resume a request, then one pool step
    always_comb begin
        pool_next   = pool_reg;
        left_next   = left_reg;
        used_next   = used_reg;
        err_next    = err_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        offset_next = offset_reg;
        target_next = target_reg;
        count_next  = count_reg;
        bound_next  = bound_reg;
        st          = ST_OK;
        val         = '0;
        done        = 1'b0;
        run         = 1'b0;
        take        = '0;
        zeros       = '0;
        rem         = '0;
        take_mask   = '0;
        drawn       = '0;

        // front of the step: new request or supplied word
        case (q_item.op) inside
            OP_BITS, OP_GEOM: begin
                if (kind_reg != KIND_NONE) begin
                    st = ST_OK;
                end else if (q_item.op == OP_BITS && q_item.too_many) begin
                    st   = ST_INVAL;
                    done = 1'b1;
                end else if (err_reg != ERR_NONE) begin
                    st   = {1'b0, err_reg};
                    done = 1'b1;
                end else begin
                    kind_next   = (q_item.op == OP_BITS) ? KIND_BITS : KIND_GEOM;
                    value_next  = '0;
                    offset_next = '0;
                    target_next = q_item.bit_count;
                    count_next  = '0;
                    bound_next  = q_item.bound;
                    run         = 1'b1;
                end
            end
            OP_WORD: begin
                if (kind_reg == KIND_NONE || left_reg != '0) begin
                    st = ST_REFUSED;
                end else if (q_item.source_fail) begin
                    pool_next = '0;
                    left_next = '0;
                    err_next  = ERR_SRC;
                    kind_next = KIND_NONE;
                    st        = ST_SRC;
                    done      = 1'b1;
                end else begin
                    pool_next = q_item.source_word[POOL_WIDTH-1:0];
                    left_next = LW'(POOL_WIDTH);
                    run       = 1'b1;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase

        // trailing zero count of the pool
        for (int i = POOL_WIDTH - 1; i >= 0; i--) begin
            if (pool_next[i]) begin
                zeros = LW'(i);
            end
        end

        // back of the step: draw from the pool
        if (run) begin
            unique case (kind_next)
                KIND_BITS: begin
                    if (left_next != '0 && offset_next < target_next) begin
                        rem       = target_next - offset_next;
                        take      = (LW'(rem) < left_next) ? LW'(rem) : left_next;
                        take_mask = (33'd1 << take) - 33'd1;
                        drawn     = pool_next[31:0] & take_mask[31:0];
                        value_next  = value_next | (drawn << offset_next);
                        pool_next   = pool_next >> take;
                        left_next   = left_next - take;
                        used_next   = sat_add(used_next, take);
                        offset_next = offset_next + 6'(take);
                    end
                    if (offset_next >= target_next) begin
                        val       = value_next;
                        st        = ST_OK;
                        done      = 1'b1;
                        kind_next = KIND_NONE;
                    end
                end
                KIND_GEOM: begin
                    if (left_next == '0) begin
                        done = 1'b0;
                    end else if (pool_next == '0) begin
                        // whole pool is zeros: count them and wait for a word
                        count_next = count_next + COUNT_W'(left_next);
                        used_next  = sat_add(used_next, left_next);
                        left_next  = '0;
                        if (count_next > {1'b0, bound_next}) begin
                            err_next  = ERR_BOUND;
                            kind_next = KIND_NONE;
                            st        = ST_BOUND;
                            done      = 1'b1;
                        end
                    end else begin
                        // first one bit found: consume it and finish
                        take       = zeros + LW'(1);
                        pool_next  = pool_next >> take;
                        left_next  = (take > left_next) ? '0 : left_next - take;
                        used_next  = sat_add(used_next, take);
                        count_next = count_next + COUNT_W'(zeros);
                        kind_next  = KIND_NONE;
                        done       = 1'b1;
                        if (count_next > {1'b0, bound_next}) begin
                            err_next = ERR_BOUND;
                            st       = ST_BOUND;
                        end else begin
                            st  = ST_OK;
                            val = count_next[VALUE_W-1:0];
                        end
                    end
                end
                default: begin
                    done = 1'b0;
                end
            endcase
        end

        need = (kind_next != KIND_NONE) && (left_next == '0);
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, used_next, need, done, st,
                             (st == ST_OK) ? val : {VALUE_W{1'b0}}};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg     <= '0;
            left_reg     <= '0;
            used_reg     <= '0;
            err_reg      <= ERR_NONE;
            kind_reg     <= KIND_NONE;
            value_reg    <= '0;
            offset_reg   <= '0;
            target_reg   <= '0;
            count_reg    <= '0;
            bound_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (fire) begin
                pool_reg   <= pool_next;
                left_reg   <= left_next;
                used_reg   <= used_next;
                err_reg    <= err_next;
                kind_reg   <= kind_next;
                value_reg  <= value_next;
                offset_reg <= offset_next;
                target_reg <= target_next;
                count_reg  <= count_next;
                bound_reg  <= bound_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= LW'(POOL_WIDTH))
        else $error("pool fill above pool width");

    a_wait_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg != KIND_NONE |-> left_reg == '0)
        else $error("request pending while pool holds bits");

    a_bits_open: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == KIND_BITS |-> offset_reg < target_reg)
        else $error("finished bits request left pending");

    a_geom_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == KIND_GEOM |-> count_reg <= {1'b0, bound_reg})
        else $error("geometric request pending past its bound");

    a_used_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> used_reg >= $past(used_reg))
        else $error("consumed bit count went down");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the random bit pool with geometric sampler. A fixed table covers
// refused words, oversize and zero-size draws, requests while busy, multi-word
// geometric runs and draws that wait for a word. Random draw and geometric
// request sequences with their source words follow; a closing table runs one
// sticky error, chosen by the seed, and the later requests. Every result is
// checked field by field against a cycle-free pool model or a typed outcome.
// ============================================================================

module testbench;
    import rbp_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int POOL_W        = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400_000;
    // keeps random geometric bounds far above any count a random run can build
    localparam logic [31:0] GEOM_FLOOR = 32'h0000_1000;

    // one request as the sender offers it, with optional hand-typed outcome
    typedef struct packed {
        logic [1:0]             cmd;
        logic [BIT_COUNT_W-1:0] cnt;
        logic [BOUND_W-1:0]     bnd;
        logic [WORD_W-1:0]      word;
        logic                   fail;
        logic                   known;
        logic [VALUE_W-1:0]     k_value;
        logic [STATUS_W-1:0]    k_status;
        logic                   k_done;
    } pool_req_t;

    // one result of the block
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                done_res;
        logic                need_word;
        logic [USED_W-1:0]   used_bits;
    } pool_result_t;

    // how the closing table reaches its sticky error
    typedef enum logic [1:0] {
        END_ZERO_RUN,
        END_LATE_ONE,
        END_SOURCE_FAIL
    } finale_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [IN_TUSER_W-1:0]   s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    // hand-typed outcome travelling beside the request
    logic                    drv_known  = 1'b0;
    logic [VALUE_W-1:0]      drv_value  = '0;
    logic [STATUS_W-1:0]     drv_status = '0;
    logic                    drv_done   = 1'b0;

    logic                    no_idle  = 1'b0;
    int                      rdy_left = 0;
    int                      cycles   = 0;
    int                      errors   = 0;
    int                      sent     = 0;

    // model of the pool
    logic [63:0]             pool_bits  = '0;
    int unsigned             pool_fill  = 0;
    logic [USED_W-1:0]       bits_used  = '0;
    logic [1:0]              sticky_err = ERR_NONE;
    kind_t                   req_kind   = KIND_NONE;
    logic [VALUE_W-1:0]      draw_value = '0;
    int unsigned             draw_offset = 0;
    int unsigned             draw_target = 0;
    logic [COUNT_W-1:0]      zero_run   = '0;
    logic [BOUND_W-1:0]      zero_bound = '0;

    pool_result_t            awaited[$];

    // tallies for the summary
    int                      n_draws = 0;
    int                      n_geoms = 0;
    int                      n_words = 0;
    int                      n_results = 0;
    logic [VALUE_W-1:0]      geo_max = '0;

    random_bit_pool_with_geometric_sampler #(
        .POOL_WIDTH (POOL_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #HALF_PERIOD aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("no end of run within %0d cycles", CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // saturating count of consumed bits
    function automatic void count_used(input int unsigned n);
        if (~bits_used < n) begin
            bits_used = '1;
        end else begin
            bits_used = bits_used + n;
        end
    endfunction

    // move the waiting request on as far as the pool allows
    function automatic logic serve_pending(output logic [2:0] st, output logic [31:0] val);
        int unsigned take;
        int unsigned zeros;
        logic [63:0] mask;
        logic [63:0] chunk;
        st = ST_OK;
        val = '0;
        while (req_kind != KIND_NONE) begin
            if (req_kind == KIND_BITS && draw_offset >= draw_target) begin
                val = draw_value;
                req_kind = KIND_NONE;
                return 1'b1;
            end
            if (pool_fill == 0) begin
                return 1'b0;
            end
            if (req_kind == KIND_BITS) begin
                // take what the draw still needs, or what the pool holds
                take = draw_target - draw_offset;
                if (take > pool_fill) begin
                    take = pool_fill;
                end
                mask = (64'd1 << take) - 64'd1;
                chunk = (pool_bits & mask) << draw_offset;
                draw_value = draw_value | chunk[31:0];
                pool_bits = (take >= 64) ? 64'd0 : (pool_bits >> take);
                pool_fill = pool_fill - take;
                count_used(take);
                draw_offset = draw_offset + take;
            end else if (pool_bits == 64'd0) begin
                // the whole rest of the pool is zeros
                zero_run = zero_run + pool_fill;
                count_used(pool_fill);
                pool_fill = 0;
                if (zero_run > {1'b0, zero_bound}) begin
                    sticky_err = ERR_BOUND;
                    req_kind = KIND_NONE;
                    st = ST_BOUND;
                    return 1'b1;
                end
            end else begin
                // zeros up to the first one, which is consumed as well
                zeros = 0;
                while (pool_bits[zeros] == 1'b0) begin
                    zeros++;
                end
                take = zeros + 1;
                pool_bits = (take >= 64) ? 64'd0 : (pool_bits >> take);
                pool_fill = (take > pool_fill) ? 0 : pool_fill - take;
                count_used(take);
                zero_run = zero_run + zeros;
                req_kind = KIND_NONE;
                if (zero_run > {1'b0, zero_bound}) begin
                    sticky_err = ERR_BOUND;
                    st = ST_BOUND;
                end else begin
                    val = zero_run[31:0];
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // result the pool gives for one request
    function automatic void predict_pool_result(input logic [1:0] cmd,
                                                input logic [5:0] cnt,
                                                input logic [31:0] bnd,
                                                input logic [63:0] word,
                                                input logic fail,
                                                output pool_result_t r);
        logic [2:0]  st;
        logic [31:0] val;
        logic        done;
        st = ST_OK;
        val = '0;
        done = 1'b0;
        if (cmd == CMD_BITS || cmd == CMD_GEOM) begin
            if (req_kind != KIND_NONE) begin
                // busy: the request is dropped
            end else if (cmd == CMD_BITS && cnt > MAX_REQUEST_BITS) begin
                st = ST_INVAL;
                done = 1'b1;
            end else if (sticky_err != ERR_NONE) begin
                st = {1'b0, sticky_err};
                done = 1'b1;
            end else begin
                if (cmd == CMD_BITS) begin
                    req_kind = KIND_BITS;
                end else begin
                    req_kind = KIND_GEOM;
                end
                draw_value = '0;
                draw_offset = 0;
                draw_target = cnt;
                zero_run = '0;
                zero_bound = bnd;
                done = serve_pending(st, val);
            end
        end else if (cmd == CMD_WORD) begin
            if (req_kind == KIND_NONE || pool_fill != 0) begin
                st = ST_REFUSED;
            end else if (fail) begin
                pool_bits = '0;
                pool_fill = 0;
                sticky_err = ERR_SRC;
                req_kind = KIND_NONE;
                st = ST_SRC;
                done = 1'b1;
            end else begin
                pool_bits = word & ({64{1'b1}} >> (64 - POOL_W));
                pool_fill = POOL_W;
                done = serve_pending(st, val);
            end
        end
        if (st != ST_OK) begin
            val = '0;
        end
        r.value = val;
        r.status = st;
        r.done_res = done;
        r.need_word = (req_kind != KIND_NONE) && (pool_fill == 0);
        r.used_bits = bits_used;
    endfunction

    // watch both channels: predict on each request, compare on each result
    always @(posedge aclk) begin : watch
        pool_result_t want;
        pool_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pool_result(s_tuser, s_tdata[5:0], s_tdata[37:6],
                                    s_tdata[101:38], s_tdata[102], want);
                if (drv_known) begin
                    want.value = drv_value;
                    want.status = drv_status;
                    want.done_res = drv_done;
                end
                awaited.push_back(want);
                if (s_tuser == CMD_BITS) n_draws++;
                if (s_tuser == CMD_GEOM) n_geoms++;
                if (s_tuser == CMD_WORD) n_words++;
            end
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[31:0];
                got.status = m_tdata[34:32];
                got.done_res = m_tdata[35];
                got.need_word = m_tdata[36];
                got.used_bits = m_tdata[100:37];
                n_results++;
                if (awaited.size() == 0) begin
                    $error("result with no request waiting: value %h status %0d",
                           got.value, got.status);
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, got.value);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res: expected %b, got %b", want.done_res, got.done_res);
                        errors++;
                    end
                    if (got.need_word !== want.need_word) begin
                        $error("need_word: expected %b, got %b",
                               want.need_word, got.need_word);
                        errors++;
                    end
                    if (got.used_bits !== want.used_bits) begin
                        $error("used_bits: expected %h, got %h",
                               want.used_bits, got.used_bits);
                        errors++;
                    end
                    if (got.done_res && got.status == ST_OK && got.value > geo_max
                        && want.need_word == 1'b0) begin
                        geo_max = got.value;
                    end
                end
            end
        end
    end

    // result side: random stalls, mostly short, with steady stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_left <= 0;
        end else if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b0;
            rdy_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 2);
        end
    end

    function automatic pool_req_t plain(input logic [1:0] cmd, input logic [5:0] cnt,
                                        input logic [31:0] bnd, input logic [63:0] word,
                                        input logic fail);
        pool_req_t r;
        r = '0;
        r.cmd = cmd;
        r.cnt = cnt;
        r.bnd = bnd;
        r.word = word;
        r.fail = fail;
        return r;
    endfunction

    function automatic pool_req_t known(input logic [1:0] cmd, input logic [5:0] cnt,
                                        input logic [31:0] bnd, input logic [63:0] word,
                                        input logic fail, input logic [31:0] value,
                                        input logic [2:0] status, input logic done);
        pool_req_t r;
        r = plain(cmd, cnt, bnd, word, fail);
        r.known = 1'b1;
        r.k_value = value;
        r.k_status = status;
        r.k_done = done;
        return r;
    endfunction

    // source words: zeros, single ones, all ones and plain random
    function automatic logic [63:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 30) return 64'd1 << $urandom_range(0, 63);
        if (pick < 40) return '1;
        return {$urandom, $urandom};
    endfunction

    // draw sizes: mostly legal, some zero, full and oversize
    function automatic logic [5:0] rand_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return 6'($urandom_range(33, 63));
        if (pick < 15) return 6'd0;
        if (pick < 25) return 6'd32;
        return 6'($urandom_range(1, 31));
    endfunction

    // random request; fields the command ignores are random too
    function automatic pool_req_t rand_req(input logic [1:0] cmd);
        pool_req_t r;
        r = plain(cmd, 6'($urandom_range(0, 63)), $urandom, {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
        case (cmd)
            CMD_BITS: r.cnt = rand_count();
            CMD_GEOM: r.bnd = $urandom | GEOM_FLOOR;
            CMD_WORD: begin
                // a wanted failing word would end the run's useful part
                r.word = rand_word();
                r.fail = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one request and hold it until it is taken
    task automatic send(input pool_req_t r);
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= {1'b0, r.fail, r.word, r.bnd, r.cnt};
        drv_known <= r.known;
        drv_value <= r.k_value;
        drv_status <= r.k_status;
        drv_done <= r.k_done;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic offer(input pool_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        send(r);
        sent++;
    endtask

    // stop sending until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited.size() != 0);
    endtask

    // stimulus
    initial begin : stimulus
        pool_req_t   opening[$];
        pool_req_t   r;
        logic [2:0]  sticky_st;
        finale_t     finale;
        int          next_phase;
        int          words;
        int unsigned pick;
        logic        paused;

        // opening table
        opening.push_back(known(CMD_NOP, '1, '1, '1, 1'b1, '0, ST_OK, 1'b0));
        opening.push_back(known(CMD_WORD, '1, '1, '1, 1'b1, '0, ST_REFUSED, 1'b0));
        opening.push_back(known(CMD_BITS, 6'd0, '0, '0, 1'b0, '0, ST_OK, 1'b1));
        opening.push_back(known(CMD_BITS, 6'd33, '0, '0, 1'b0, '0, ST_INVAL, 1'b1));
        opening.push_back(known(CMD_BITS, 6'd63, '1, '1, 1'b1, '0, ST_INVAL, 1'b1));
        opening.push_back(plain(CMD_BITS, 6'd32, '0, '0, 1'b0));
        opening.push_back(known(CMD_GEOM, 6'd0, '1, '0, 1'b0, '0, ST_OK, 1'b0));
        opening.push_back(known(CMD_BITS, 6'd5, '0, '0, 1'b0, '0, ST_OK, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, 64'hA5A5_5A5A_FFFF_FFFF, 1'b0));
        opening.push_back(known(CMD_WORD, 6'd0, '0, '0, 1'b0, '0, ST_REFUSED, 1'b0));
        opening.push_back(plain(CMD_BITS, 6'd32, '0, '0, 1'b0));
        // geometric: a one right at bit 0 against a zero bound
        opening.push_back(plain(CMD_GEOM, 6'd0, 32'd0, '0, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, 64'd1, 1'b0));
        // geometric spanning three words
        opening.push_back(plain(CMD_GEOM, 6'd0, '1, '0, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, 64'd0, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, 64'h8000_0000_0000_0000, 1'b0));
        // draws and a geometric sample that wait for a word and then use it up
        opening.push_back(plain(CMD_BITS, 6'd1, '0, '0, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, '1, 1'b0));
        opening.push_back(plain(CMD_BITS, 6'd31, '0, '0, 1'b0));
        opening.push_back(plain(CMD_BITS, 6'd32, '0, '0, 1'b0));
        opening.push_back(plain(CMD_GEOM, 6'd0, 32'h0000_00FF, '0, 1'b0));
        opening.push_back(plain(CMD_WORD, 6'd0, '0, 64'h0000_0001_0000_0000, 1'b0));
        opening.push_back(plain(CMD_BITS, 6'd31, '0, '0, 1'b0));

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening[i]) begin
            offer(opening[i]);
        end

        // random draw and geometric sequences with their words
        next_phase = 0;
        paused = 1'b0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_phase) begin
                no_idle <= ($urandom_range(0, 3) == 0);
                next_phase = sent + $urandom_range(60, 160);
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                offer(rand_req(2'($urandom_range(0, 3))));
            end else if (pick < 58) begin
                offer(rand_req(CMD_BITS));
                words = $urandom_range(0, 2);
                repeat (words) offer(rand_req(CMD_WORD));
            end else begin
                offer(rand_req(CMD_GEOM));
                words = $urandom_range(1, 3);
                repeat (words) offer(rand_req(CMD_WORD));
            end
        end
        no_idle <= 1'b0;

        // finish whatever is waiting and empty the pool
        drain();
        while (req_kind != KIND_NONE || pool_fill != 0) begin
            if (req_kind != KIND_NONE) begin
                offer(plain(CMD_WORD, 6'd0, '0, '1, 1'b0));
            end else begin
                offer(plain(CMD_BITS, (pool_fill > 32) ? 6'd32 : pool_fill[5:0],
                            '0, '0, 1'b0));
            end
            drain();
        end

        // one sticky error per run, the seed picks which
        finale = finale_t'($urandom_range(0, 2));
        case (finale)
            END_ZERO_RUN: begin
                // a whole zero word passes the bound
                sticky_st = ST_BOUND;
                offer(plain(CMD_GEOM, 6'd0, 32'd0, '0, 1'b0));
                offer(known(CMD_WORD, 6'd0, '0, 64'd0, 1'b0, '0, ST_BOUND, 1'b1));
            end
            END_LATE_ONE: begin
                // the first one comes after the bound
                sticky_st = ST_BOUND;
                offer(plain(CMD_GEOM, 6'd0, 32'd5, '0, 1'b0));
                offer(known(CMD_WORD, 6'd0, '0, 64'h80, 1'b0, '0, ST_BOUND, 1'b1));
            end
            default: begin
                sticky_st = ST_SRC;
                offer(plain(CMD_GEOM, 6'd0, '1, '0, 1'b0));
                offer(known(CMD_WORD, 6'd0, '0, '1, 1'b1, '0, ST_SRC, 1'b1));
            end
        endcase

        // requests after the sticky error
        offer(known(CMD_BITS, 6'd7, '0, '0, 1'b0, '0, sticky_st, 1'b1));
        offer(known(CMD_GEOM, 6'd0, '1, '0, 1'b0, '0, sticky_st, 1'b1));
        offer(known(CMD_BITS, 6'd0, '0, '0, 1'b0, '0, sticky_st, 1'b1));
        offer(known(CMD_BITS, 6'd40, '0, '0, 1'b0, '0, ST_INVAL, 1'b1));
        offer(known(CMD_WORD, 6'd0, '0, '1, 1'b1, '0, ST_REFUSED, 1'b0));
        offer(known(CMD_NOP, 6'd0, '0, '0, 1'b0, '0, ST_OK, 1'b0));
        repeat (20) begin
            r = rand_req(2'($urandom_range(0, 3)));
            offer(r);
        end

        // wait for the last results, then let the bench settle
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (awaited.size() != 0) begin
            $error("%0d results never arrived", awaited.size());
            errors++;
        end

        $display("covered %0d draws, %0d geometric samples, %0d source words, %0d results",
                 n_draws, n_geoms, n_words, n_results);
        $display("largest finished value %0d, run closed on sticky status %0d",
                 geo_max, sticky_st);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
